@@ design/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FFBA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("allocator assertion failed");
`define FFBA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("allocator forbidden condition seen");
`else
`define FFBA_ASSERT(lbl, clk, rstn, prop)
`define FFBA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ design/ffba_pkg.sv @@
// Package: constants, payload types and codes of the first-fit allocator.
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 24;
    localparam int ADDR_BITS    = 24;
    localparam int FIELD_W      = 24;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int END_W = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 2;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] req_size;
        logic [FIELD_W-1:0] free_addr;
    } t_request;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] addr;
        logic               reused;
    } t_result;

    typedef struct packed {
        logic                 free;
        logic [FIELD_W-1:0]   size;
        logic [ADDR_BITS-1:0] start;
    } t_entry;

endpackage

`default_nettype wire

@@ design/ffba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/ffba_scan.sv @@
// Request sequencer: walks the table one entry per cycle; frees, reuses, appends.
`default_nettype none

module ffba_scan import ffba_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_request           i_req,
    input  wire logic [FIELD_W-1:0] i_heap_limit,
    output logic                    o_busy,
    output logic                    o_res_valid,
    output t_result                 o_res,
    input  wire logic               i_res_take
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_DONE
    } t_state;

    localparam logic [END_W-1:0] LIM_MAX = END_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [END_W-1:0] HDR     = END_W'(HEADER_BYTES);

    t_state               r_state;
    t_request             r_req;
    t_result              r_res;
    logic [CNT_W-1:0]     r_count;
    logic [ADDR_BITS-1:0] r_top;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_issue;
    logic                 r_pend;
    logic [IDX_W-1:0]     r_pend_idx;
    logic                 r_pend_last;

    t_entry               rd_data;
    t_entry               wr_data;
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_waddr;
    logic [$bits(t_entry)-1:0] rd_raw;

    logic                 is_free;
    logic [END_W-1:0]     cand_addr;
    logic                 hit;
    logic                 last_issue;
    logic [END_W-1:0]     tail_end;
    logic [END_W-1:0]     limit;
    logic [END_W-1:0]     limit_ext;
    logic [END_W-1:0]     top_addr;
    logic                 exhausted;
    logic                 full;

    assign rd_data    = t_entry'(rd_raw);
    assign is_free    = (r_req.req_type == REQ_FREE);
    assign cand_addr  = END_W'(rd_data.start) + HDR;
    assign hit        = r_pend && (is_free ? (cand_addr == END_W'(r_req.free_addr))
                                           : (rd_data.free &&
                                              (rd_data.size >= r_req.req_size)));
    assign last_issue = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));
    assign top_addr   = END_W'(r_top) + HDR;
    assign tail_end   = top_addr + END_W'(r_req.req_size);
    assign limit_ext  = END_W'(i_heap_limit);
    assign limit      = (limit_ext > LIM_MAX) ? LIM_MAX : limit_ext;
    assign exhausted  = (tail_end > limit);
    assign full       = (r_count == CNT_W'(MAX_BLOCKS));

    always_comb begin
        ram_re    = (r_state == S_SCAN) && r_issue;
        ram_we    = ((r_state == S_SCAN) && hit) ||
                    ((r_state == S_TAIL) && !exhausted && !full);
        ram_waddr = r_pend_idx;
        wr_data   = '{free: is_free, size: rd_data.size, start: rd_data.start};
        if (r_state == S_TAIL) begin
            ram_waddr = r_count[IDX_W-1:0];
            wr_data   = '{free: 1'b0, size: r_req.req_size, start: r_top};
        end
    end

    ffba_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_data),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_top   <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req  <= i_req;
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (i_req.req_type == REQ_ALLOC && i_req.req_size == '0) begin
                            r_res   <= '{status: ST_ZERO, addr: '0, reused: 1'b0};
                            r_state <= S_DONE;
                        end else if (i_req.req_type == REQ_FREE &&
                                     i_req.free_addr == '0) begin
                            r_res   <= '{status: ST_OK, addr: '0, reused: 1'b0};
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            if (i_req.req_type == REQ_FREE) begin
                                r_res   <= '{status: ST_UNKNOWN, addr: '0, reused: 1'b0};
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_TAIL;
                            end
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_pend      <= r_issue;
                    r_pend_idx  <= r_idx;
                    r_pend_last <= last_issue;
                    if (r_issue) begin
                        r_idx <= r_idx + IDX_W'(1);
                        if (last_issue) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (hit) begin
                        r_issue <= 1'b0;
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                        if (is_free) begin
                            r_res <= '{status: ST_OK, addr: '0, reused: 1'b0};
                        end else begin
                            r_res <= '{status: ST_OK, addr: FIELD_W'(cand_addr),
                                       reused: 1'b1};
                        end
                    end else if (r_pend && r_pend_last) begin
                        r_pend <= 1'b0;
                        if (is_free) begin
                            r_res   <= '{status: ST_UNKNOWN, addr: '0, reused: 1'b0};
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_TAIL;
                        end
                    end
                end
                S_TAIL: begin
                    r_state <= S_DONE;
                    if (exhausted) begin
                        r_res <= '{status: ST_EXHAUSTED, addr: '0, reused: 1'b0};
                    end else if (full) begin
                        r_res <= '{status: ST_FULL, addr: '0, reused: 1'b0};
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                        r_top   <= tail_end[ADDR_BITS-1:0];
                        r_res   <= '{status: ST_OK, addr: FIELD_W'(top_addr),
                                     reused: 1'b0};
                    end
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ design/first_fit_block_allocator_unit.sv @@
// First-fit heap block allocator: top level with config register and output stage.
//
// Requests arrive on i_valid / i_req and are taken when o_stall is low. A request
// either allocates (req_type 0, req_size bytes) or frees (req_type 1, free_addr).
// Results leave on o_valid / o_res and are taken when i_stall is low.
// i_cfg_we writes heap_limit from i_cfg_wdata; write it only while idle.
// One request is processed at a time; o_stall stays high until its result has
// moved into the output register.
// The table RAM is read one entry per cycle, stopping at the first hit; a zero-size
// allocate, a null free and any request on an empty table skip the table read.
// Reset (synchronous, active low) empties the table, zeroes the heap top and sets
// heap_limit to all ones; table contents are not cleared and need no sweep.
// A stalled result holds in the output register; the next result then waits in
// the sequencer, which holds off new requests.
`default_nettype none
`include "assert_macros.svh"

module first_fit_block_allocator_unit import ffba_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire t_request           i_req,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output t_result                 o_res,
    input  wire logic               i_cfg_we,
    input  wire logic [FIELD_W-1:0] i_cfg_wdata
);

    logic [FIELD_W-1:0] r_heap_limit;
    logic               r_ovalid;
    t_result            r_out;

    logic               busy;
    logic               start;
    logic               res_valid;
    t_result            res;
    logic               take;

    assign o_stall = busy;
    assign start   = i_valid && !busy;
    assign take    = res_valid && (!r_ovalid || !i_stall);

    ffba_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_req        (i_req),
        .i_heap_limit (r_heap_limit),
        .o_busy       (busy),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_take   (take)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_limit <= '1;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap_limit <= i_cfg_wdata;
            end
            if (take) begin
                r_ovalid <= 1'b1;
                r_out    <= res;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_out;

    `FFBA_ASSERT(a_accept_busy, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    `FFBA_NEVER(a_fail_no_addr, i_clk, i_rst_n, o_valid && o_res.status != ST_OK && o_res.addr != '0)
    `FFBA_ASSERT(a_reuse_ok, i_clk, i_rst_n, (o_valid && o_res.reused) |-> (o_res.status == ST_OK))

endmodule

`default_nettype wire

@@ test/tb_first_fit_block_allocator_unit.sv @@
// Self-checking testbench for the first-fit block allocator unit.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam logic [END_W-1:0] ADDR_CAP = END_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_request           i_req;
    logic               o_valid;
    logic               i_stall;
    t_result            o_res;
    logic               i_cfg_we;
    logic [FIELD_W-1:0] i_cfg_wdata;

    first_fit_block_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block table and heap
    t_entry               shadow_blocks [MAX_BLOCKS];
    int                   shadow_count = 0;
    logic [ADDR_BITS:0]   shadow_top   = '0;
    logic [FIELD_W-1:0]   shadow_limit = '1;

    t_result awaited_responses [$];
    int      mismatches        = 0;
    int      idle_cycles       = 0;
    int      hold_start_count  = 0;
    bit      tx_idle_on        = 1'b1;
    bit      rx_idle_on        = 1'b1;

    function automatic t_result allocator_response(input t_request r);
        t_result          res;
        logic [END_W-1:0] new_end;
        logic [END_W-1:0] cap;
        int               hit;
        res = '0;
        res.status = ST_OK;
        hit = -1;
        if (r.req_type == REQ_ALLOC) begin
            if (r.req_size == '0) begin
                res.status = ST_ZERO;
            end else begin
                for (int i = 0; i < shadow_count && hit < 0; i++) begin
                    if (shadow_blocks[i].free && shadow_blocks[i].size >= r.req_size)
                        hit = i;
                end
                if (hit >= 0) begin
                    shadow_blocks[hit].free = 1'b0;
                    res.addr = FIELD_W'(END_W'(shadow_blocks[hit].start) + HEADER_BYTES);
                    res.reused = 1'b1;
                end else begin
                    cap = (END_W'(shadow_limit) > ADDR_CAP) ? ADDR_CAP : END_W'(shadow_limit);
                    new_end = END_W'(shadow_top) + END_W'(HEADER_BYTES) + END_W'(r.req_size);
                    if (new_end > cap) begin
                        res.status = ST_EXHAUSTED;
                    end else if (shadow_count >= MAX_BLOCKS) begin
                        res.status = ST_FULL;
                    end else begin
                        shadow_blocks[shadow_count].free  = 1'b0;
                        shadow_blocks[shadow_count].size  = r.req_size;
                        shadow_blocks[shadow_count].start = ADDR_BITS'(shadow_top);
                        shadow_count++;
                        res.addr = FIELD_W'(END_W'(shadow_top) + HEADER_BYTES);
                        shadow_top = new_end[ADDR_BITS:0];
                    end
                end
            end
        end else if (r.free_addr != '0) begin
            for (int i = 0; i < shadow_count && hit < 0; i++) begin
                if (END_W'(shadow_blocks[i].start) + HEADER_BYTES == END_W'(r.free_addr))
                    hit = i;
            end
            if (hit >= 0)
                shadow_blocks[hit].free = 1'b1;
            else
                res.status = ST_UNKNOWN;
        end
        return res;
    endfunction

    function automatic int idle_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [FIELD_W-1:0] block_addr(input int k);
        return FIELD_W'(END_W'(shadow_blocks[k].start) + HEADER_BYTES);
    endfunction

    function automatic t_request alloc_request(input logic [FIELD_W-1:0] size);
        t_request r;
        r.req_type  = REQ_ALLOC;
        r.req_size  = size;
        r.free_addr = FIELD_W'($urandom());
        return r;
    endfunction

    function automatic t_request free_request(input logic [FIELD_W-1:0] addr);
        t_request r;
        r.req_type  = REQ_FREE;
        r.req_size  = FIELD_W'($urandom());
        r.free_addr = addr;
        return r;
    endfunction

    // mostly allocate/free pairs on live blocks, some noise
    function automatic t_request pick_request();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        k = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        if (pick < 25)
            return alloc_request(FIELD_W'($urandom_range(1, 64)));
        else if (pick < 45 && shadow_count > 0)
            return alloc_request(FIELD_W'($urandom_range(1, shadow_blocks[k].size)));
        else if (pick < 80 && shadow_count > 0)
            return free_request(block_addr(k));
        else if (pick < 84)
            return free_request('0);
        else if (pick < 88)
            return alloc_request('0);
        else if (pick < 91 && shadow_count > 0)
            return free_request(block_addr(k) + FIELD_W'($urandom_range(1, 3)));
        else if (pick < 94)
            return free_request(FIELD_W'($urandom()));
        else if (shadow_count < MAX_BLOCKS)
            return alloc_request(24'hFFFFFF - FIELD_W'($urandom_range(0, 15)));
        return alloc_request(FIELD_W'($urandom()));
    endfunction

    task automatic send_request(input t_request r);
        int gap;
        gap = tx_idle_on ? idle_length() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        awaited_responses.push_back(allocator_response(r));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_heap_limit(input logic [FIELD_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_limit = value;
    endtask

    task automatic test_zero_and_null_requests();
        send_request(alloc_request('0));
        send_request(free_request('0));
        send_request(free_request(24'hFFFFFF));
        send_request(alloc_request(24'hFFFFFF));
    endtask

    task automatic test_first_fit_reuse();
        send_request(alloc_request(24'd1));
        send_request(alloc_request(24'd100));
        send_request(free_request(block_addr(0)));
        send_request(free_request(block_addr(0)));
        send_request(alloc_request(24'd1));
        send_request(free_request(block_addr(1)));
        send_request(alloc_request(24'd101));
        send_request(alloc_request(24'd50));
        send_request(free_request(block_addr(1) + 24'd1));
    endtask

    task automatic test_heap_limit();
        write_heap_limit(FIELD_W'(shadow_top + HEADER_BYTES + 10));
        send_request(alloc_request(24'd11));
        send_request(alloc_request(24'd10));
        send_request(alloc_request(24'd1));
        send_request(free_request(block_addr(2)));
        write_heap_limit('0);
        send_request(alloc_request(24'd1));
        send_request(alloc_request(24'd1));
        write_heap_limit('1);
    endtask

    // exhaustion is reported ahead of a full table
    task automatic test_table_full();
        while (shadow_count < MAX_BLOCKS)
            send_request(alloc_request(FIELD_W'($urandom_range(1, 64))));
        send_request(alloc_request(24'd4096));
        send_request(alloc_request('0));
        write_heap_limit(FIELD_W'(shadow_top + HEADER_BYTES + 100));
        send_request(alloc_request(24'd4096));
        send_request(alloc_request(24'd76));
        write_heap_limit('1);
    endtask

    task automatic test_random_traffic(input int count, input logic [FIELD_W-1:0] limit);
        bit quiet;
        write_heap_limit(limit);
        for (int n = 0; n < count; n++) begin
            if (n % 64 == 0) begin
                quiet = ($urandom_range(0, 3) == 0);
                tx_idle_on = !quiet;
                rx_idle_on = !quiet;
            end
            send_request(pick_request());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        wait_for_results();
        tx_idle_on = 1'b0;
        hold_start_count++;
        repeat (40) send_request(pick_request());
        tx_idle_on = 1'b1;
        wait_for_results();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_zero_and_null_requests();
        test_first_fit_reuse();
        test_heap_limit();
        test_table_full();
        test_random_traffic(300, '1);
        test_random_traffic(300, FIELD_W'(shadow_top + $urandom_range(0, 120)));
        test_random_traffic(200, '0);
        test_random_traffic(300, FIELD_W'($urandom()));
        test_output_backpressure();
        test_random_traffic(350, '1);

        wait_for_results();
        repeat (MAX_BLOCKS + 8) @(posedge i_clk);
        if (mismatches == 0 && awaited_responses.size() == 0)
            $display("first_fit_block_allocator_unit test passed");
        else
            $display("first_fit_block_allocator_unit test failed");
        $finish;
    end

    // result side: random stalls plus the long hold-off
    initial begin : result_sink
        int hold_left;
        int stall_left;
        int holds_seen;
        hold_left  = 0;
        stall_left = 0;
        holds_seen = 0;
        i_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_start_count != holds_seen) begin
                holds_seen = hold_start_count;
                hold_left  = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_idle_on && stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = rx_idle_on ? idle_length() : 0;
            end
        end
    end

    always @(posedge i_clk) begin : response_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_responses.size() == 0) begin
                $display("%0t: response with no request pending: status %0d addr %0h reused %0b",
                         $time, o_res.status, o_res.addr, o_res.reused);
                mismatches++;
            end else begin
                want = awaited_responses.pop_front();
                if (o_res.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, o_res.status);
                    mismatches++;
                end
                if (o_res.addr !== want.addr) begin
                    $display("%0t: addr expected %0h, got %0h", $time, want.addr, o_res.addr);
                    mismatches++;
                end
                if (o_res.reused !== want.reused) begin
                    $display("%0t: reused expected %0b, got %0b",
                             $time, want.reused, o_res.reused);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("first_fit_block_allocator_unit test failed");
            $finish;
        end
    end

endmodule
